### hdl/hrsg_pkg.sv
// ----------------------------------------------------------------------------
// hrsg_pkg
// Types, constants and offset helpers shared by the hex ring/spiral generator.
// ----------------------------------------------------------------------------
package hrsg_pkg;

    localparam int COORD_BITS = 16;
    localparam int RAD_BITS   = 3;
    localparam int SIDE_BITS  = 3;
    localparam int NUM_SIDES  = 6;
    localparam int NUM_AXES   = 3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [RAD_BITS-1:0]   t_rad;
    typedef logic        [SIDE_BITS-1:0]  t_side;

    typedef enum logic {
        OP_RING   = 1'b0,
        OP_SPIRAL = 1'b1
    } t_op;

    // Input request
    typedef struct packed {
        logic   op;
        t_coord center_q;
        t_coord center_r;
        t_coord center_s;
        t_rad   radius;
    } t_req;

    // One emitted cell
    typedef struct packed {
        t_coord cell_q;
        t_coord cell_r;
        t_coord cell_s;
        logic   last;
    } t_cell;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CENTER,
        S_RING
    } t_state;

    // Sign of one axis of a unit hex direction
    typedef enum logic [1:0] {
        DIR_ZERO,
        DIR_POS,
        DIR_NEG
    } t_dir;

    // Corner direction per side (q, r, s): LD, RD, R, RU, LU, L
    localparam t_dir CORNER_DIR [NUM_SIDES][NUM_AXES] = '{
        '{DIR_NEG,  DIR_POS,  DIR_ZERO},
        '{DIR_ZERO, DIR_POS,  DIR_NEG },
        '{DIR_POS,  DIR_ZERO, DIR_NEG },
        '{DIR_POS,  DIR_NEG,  DIR_ZERO},
        '{DIR_ZERO, DIR_NEG,  DIR_POS },
        '{DIR_NEG,  DIR_ZERO, DIR_POS }
    };

    // Walk direction along each side: R, RU, LU, L, LD, RD
    localparam t_dir SIDE_DIR [NUM_SIDES][NUM_AXES] = '{
        '{DIR_POS,  DIR_ZERO, DIR_NEG },
        '{DIR_POS,  DIR_NEG,  DIR_ZERO},
        '{DIR_ZERO, DIR_NEG,  DIR_POS },
        '{DIR_NEG,  DIR_ZERO, DIR_POS },
        '{DIR_NEG,  DIR_POS,  DIR_ZERO},
        '{DIR_ZERO, DIR_POS,  DIR_NEG }
    };

    // dir * val, as a coordinate-width offset
    function automatic t_coord scale(input t_dir dir, input t_rad val);
        t_coord ext;
        ext = t_coord'({{(COORD_BITS-RAD_BITS){1'b0}}, val});
        case (dir)
            DIR_POS: scale = ext;
            DIR_NEG: scale = -ext;
            default: scale = '0;
        endcase
    endfunction

    // Controller to datapath
    typedef struct packed {
        logic  load_center;
        logic  emit;
        logic  sel_center;
        logic  last;
        t_rad  k;
        t_rad  i;
        t_side side;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
    } t_dp_sts;

endpackage

### hdl/hrsg_datapath.sv
// ----------------------------------------------------------------------------
// hrsg_datapath
// Holds the center, forms each cell from corner and side offsets, and keeps
// the output register.
// ----------------------------------------------------------------------------
module hrsg_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrsg_pkg::t_req  i_req,
    input  hrsg_pkg::t_dp_cmd i_cmd,
    output hrsg_pkg::t_dp_sts o_sts,
    output logic            o_cell_valid,
    input  logic            i_cell_ready,
    output hrsg_pkg::t_cell o_cell
);
    import hrsg_pkg::*;

    t_coord r_ctr [NUM_AXES];
    t_coord n_pos [NUM_AXES];
    logic   r_valid;
    logic   n_valid;
    t_cell  r_cell;
    t_cell  n_cell;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (i_cmd.sel_center) begin
                n_pos[a] = r_ctr[a];
            end else begin
                n_pos[a] = r_ctr[a]
                         + scale(CORNER_DIR[i_cmd.side][a], i_cmd.k)
                         + scale(SIDE_DIR[i_cmd.side][a], i_cmd.i);
            end
        end
    end

    assign o_sts.slot_free = !r_valid || i_cell_ready;

    always_comb begin
        n_valid = r_valid;
        n_cell  = r_cell;
        if (i_cell_ready) begin
            n_valid = 1'b0;
        end
        if (i_cmd.emit) begin
            n_valid       = 1'b1;
            n_cell.cell_q = n_pos[0];
            n_cell.cell_r = n_pos[1];
            n_cell.cell_s = n_pos[2];
            n_cell.last   = i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (i_cmd.load_center) begin
            r_ctr[0] <= i_req.center_q;
            r_ctr[1] <= i_req.center_r;
            r_ctr[2] <= i_req.center_s;
        end
    end

    assign o_cell_valid = r_valid;
    assign o_cell       = r_cell;

endmodule

### hdl/hrsg_ctrl.sv
// ----------------------------------------------------------------------------
// hrsg_ctrl
// Sequencer: walks center, rings, steps and sides, one cell per free slot.
// ----------------------------------------------------------------------------
module hrsg_ctrl #(
    parameter int MAX_RADIUS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  hrsg_pkg::t_req    i_req,
    input  hrsg_pkg::t_dp_sts i_sts,
    output hrsg_pkg::t_dp_cmd o_cmd
);
    import hrsg_pkg::*;

    localparam t_rad RAD_LIMIT = t_rad'(MAX_RADIUS);
    localparam t_side LAST_SIDE = t_side'(NUM_SIDES - 1);

    t_state r_state, n_state;
    t_rad   r_k, n_k;
    t_rad   r_i, n_i;
    t_side  r_side, n_side;
    t_rad   r_kmax, n_kmax;
    t_rad   rad_sat;
    logic   ring_last;

    assign rad_sat   = (i_req.radius > RAD_LIMIT) ? RAD_LIMIT : i_req.radius;
    assign ring_last = (r_k == r_kmax) && (r_i == r_k - t_rad'(1))
                    && (r_side == LAST_SIDE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_side  <= '0;
            r_kmax  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_side  <= n_side;
            r_kmax  <= n_kmax;
        end
    end

    always_comb begin
        n_state           = r_state;
        n_k               = r_k;
        n_i               = r_i;
        n_side            = r_side;
        n_kmax            = r_kmax;
        o_req_ready       = 1'b0;
        o_cmd.load_center = 1'b0;
        o_cmd.emit        = 1'b0;
        o_cmd.sel_center  = 1'b0;
        o_cmd.last        = 1'b0;
        o_cmd.k           = r_k;
        o_cmd.i           = r_i;
        o_cmd.side        = r_side;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_center = 1'b1;
                    n_kmax = rad_sat;
                    n_i    = '0;
                    n_side = '0;
                    if (rad_sat != '0) begin
                        if (i_req.op == OP_SPIRAL) begin
                            n_k     = t_rad'(1);
                            n_state = S_CENTER;
                        end else begin
                            n_k     = rad_sat;
                            n_state = S_RING;
                        end
                    end
                end
            end
            S_CENTER: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.sel_center = 1'b1;
                    n_state          = S_RING;
                end
            end
            S_RING: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = ring_last;
                    if (r_side == LAST_SIDE) begin
                        n_side = '0;
                        if (r_i == r_k - t_rad'(1)) begin
                            n_i = '0;
                            n_k = r_k + t_rad'(1);
                        end else begin
                            n_i = r_i + t_rad'(1);
                        end
                    end else begin
                        n_side = r_side + t_side'(1);
                    end
                    if (ring_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/hex_ring_spiral_generator_core.sv
// ----------------------------------------------------------------------------
// hex_ring_spiral_generator_core
// Emits the cube-coordinate cells of a hex ring, or of a full spiral.
//
// A request carries a center (q, r, s), a radius and an op. Op ring emits the
// 6*radius cells at that distance; op spiral emits the center, then rings 1 up
// to radius. Each ring of radius k is walked as k steps, six cells per step,
// one on each side. Radius above MAX_RADIUS saturates; radius 0 is accepted
// and emits nothing. Coordinates wrap at 16 bits and the center is not checked
// for q + r + s = 0. Rate: one cell per cycle while the consumer keeps up. A
// request is accepted in idle before its first cell is emitted, and a radius
// 0 request leaves the generator in idle; no cell is emitted while the
// consumer stalls a full output register.
// The next request is taken in the cycle after the last cell is loaded into
// the output register, even while that cell still waits to be taken.
// ----------------------------------------------------------------------------
module hex_ring_spiral_generator_core #(
    parameter int MAX_RADIUS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // request channel
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  hrsg_pkg::t_req  i_req,
    // cell channel
    output logic            o_cell_valid,
    input  logic            i_cell_ready,
    output hrsg_pkg::t_cell o_cell
);
    import hrsg_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: state, ring radius k, step i, side
    hrsg_ctrl #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // center register, offset adders, output register
    hrsg_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_cell_valid (o_cell_valid),
        .i_cell_ready (i_cell_ready),
        .o_cell       (o_cell)
    );

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hex ring/spiral generator core.
//
// Requests go in over a valid/ready channel; every accepted request is
// expanded here into the list of cells it must produce, and each cell taken
// from the output channel is checked field by field against the oldest cell
// still owed. A short directed table covers radius zero, saturation, both
// modes, wrapping at both coordinate extremes and off-plane centers; then
// random requests follow. Both channels idle and stall at random, with one
// calm stretch and a full drain pause in the middle of the random part.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hrsg_pkg::*;

    localparam int MAX_RAD        = 4;
    localparam int N_RANDOM       = 131;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 20;     // quiet time after the last cell

    // How a directed row is checked: by the predictor, by typed values, or by expecting nothing
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,       // radius zero: nothing may come out
        CHK_UNIT_RING   // ring of radius 1 around the origin
    } t_chk;

    typedef struct packed {
        t_op    op;
        t_coord q;
        t_coord r;
        t_coord s;
        t_rad   rad;
        t_chk   chk;
    } t_row;

    // Corner offset and walk direction for each of the six sides, as (q, r, s)
    localparam int CORNER [6][3] = '{
        '{-1, 1, 0}, '{0, 1, -1}, '{1, 0, -1}, '{1, -1, 0}, '{0, -1, 1}, '{-1, 0, 1}
    };
    localparam int WALK [6][3] = '{
        '{1, 0, -1}, '{1, -1, 0}, '{0, -1, 1}, '{-1, 0, 1}, '{-1, 1, 0}, '{0, 1, -1}
    };

    // The six neighbors of the origin, in emission order
    localparam t_cell UNIT_RING [6] = '{
        '{-16'sd1,  16'sd1,  16'sd0, 1'b0},
        '{ 16'sd0,  16'sd1, -16'sd1, 1'b0},
        '{ 16'sd1,  16'sd0, -16'sd1, 1'b0},
        '{ 16'sd1, -16'sd1,  16'sd0, 1'b0},
        '{ 16'sd0, -16'sd1,  16'sd1, 1'b0},
        '{-16'sd1,  16'sd0,  16'sd1, 1'b1}
    };

    localparam int N_DIRECTED = 19;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{OP_RING,   16'sd0,    16'sd0,    16'sd0,    3'd1, CHK_UNIT_RING},
        '{OP_RING,   16'sd0,    16'sd0,    16'sd0,    3'd0, CHK_NONE},
        '{OP_SPIRAL, 16'sd0,    16'sd0,    16'sd0,    3'd0, CHK_NONE},
        '{OP_SPIRAL, 16'sd5,   -16'sd3,   -16'sd2,    3'd1, CHK_MODEL},
        '{OP_RING,   16'sd10,  -16'sd20,   16'sd10,   3'd2, CHK_MODEL},
        '{OP_RING,   16'sd0,    16'sd0,    16'sd0,    3'd4, CHK_MODEL},
        '{OP_SPIRAL, 16'sd0,    16'sd0,    16'sd0,    3'd4, CHK_MODEL},
        // radius above the maximum saturates
        '{OP_RING,   16'sd1,    16'sd2,    16'sd3,    3'd5, CHK_MODEL},
        '{OP_SPIRAL, -16'sd7,   16'sd7,    16'sd0,    3'd7, CHK_MODEL},
        // wrap past the positive and negative ends
        '{OP_RING,   16'h7FFF,  16'h7FFF,  16'h7FFF,  3'd2, CHK_MODEL},
        '{OP_SPIRAL, 16'h8000,  16'h8000,  16'h8000,  3'd3, CHK_MODEL},
        '{OP_RING,   16'h7FFE,  16'h8001,  16'h0001,  3'd4, CHK_MODEL},
        '{OP_SPIRAL, 16'hFFFF,  16'hFFFF,  16'hFFFF,  3'd2, CHK_MODEL},
        '{OP_RING,   16'h5555,  16'hAAAA,  16'h0001,  3'd6, CHK_MODEL},
        // a center off the q + r + s = 0 plane, then further on-plane rows
        '{OP_SPIRAL, 16'sd100,  16'sd200, -16'sd5,    3'd3, CHK_MODEL},
        '{OP_RING,   16'h8000,  16'h7FFF,  16'h0001,  3'd3, CHK_MODEL},
        '{OP_RING,   16'sd1234, -16'sd1234, 16'sd0,   3'd0, CHK_NONE},
        '{OP_SPIRAL, 16'h7FFC,  16'h8003,  16'h0001,  3'd7, CHK_MODEL},
        '{OP_RING,   16'sd3,   -16'sd1,   -16'sd2,    3'd1, CHK_MODEL}
    };

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  req_valid  = 1'b0;
    logic  req_ready;
    t_req  req_bus    = '0;
    logic  cell_valid;
    logic  cell_ready = 1'b0;
    t_cell cell_bus;

    t_cell       cells_due [$];     // cells owed by accepted requests, oldest first
    int unsigned errors      = 0;
    int unsigned idle_cycles = 0;
    bit          calm        = 1'b0; // no new random gaps or stalls on either side while set

    hex_ring_spiral_generator_core #(
        .MAX_RADIUS (MAX_RAD)
    ) u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .o_req_ready  (req_ready),
        .i_req        (req_bus),
        .o_cell_valid (cell_valid),
        .i_cell_ready (cell_ready),
        .o_cell       (cell_bus)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Mostly back to back, often a few cycles, now and then a long gap
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Extremes and small values dominate; full-range values cover every bit
    function automatic t_coord random_coord();
        case ($urandom_range(0, 3))
            0:       return t_coord'(32767 - int'($urandom_range(0, 4)));
            1:       return t_coord'(-32768 + int'($urandom_range(0, 4)));
            2:       return t_coord'(int'($urandom_range(0, 16)) - 8);
            default: return t_coord'($urandom);
        endcase
    endfunction

    // Small radii most of the time, with zero and the saturating codes mixed in
    function automatic t_rad random_radius();
        case ($urandom_range(0, 9))
            0:       return t_rad'(0);
            1, 2:    return t_rad'(1);
            3, 4:    return t_rad'(2);
            5:       return t_rad'(3);
            6, 7:    return t_rad'(4);
            8:       return t_rad'($urandom_range(5, 7));
            default: return t_rad'($urandom_range(0, 7));
        endcase
    endfunction

    // Add one cell at the tail of the owed list
    function automatic void owe_cell(input t_cell due);
        cells_due = {cells_due, due};
    endfunction

    // Append every cell a request must produce. Each ring of radius k walks
    // k steps; a step visits all six sides, each at its corner plus i steps
    // along that side. Sums are taken wide and cut back to 16 bits to wrap.
    function automatic void expand_request(input t_req req);
        int    rad;
        int    k_first;
        t_cell next_cell;
        rad = (int'(req.radius) > MAX_RAD) ? MAX_RAD : int'(req.radius);
        if (rad == 0)
            return;
        if (req.op == OP_SPIRAL) begin
            next_cell = '{req.center_q, req.center_r, req.center_s, 1'b0};
            owe_cell(next_cell);
            k_first = 1;
        end else begin
            k_first = rad;
        end
        for (int k = k_first; k <= rad; k++) begin
            for (int i = 0; i < k; i++) begin
                for (int side = 0; side < 6; side++) begin
                    next_cell.cell_q = t_coord'(int'(req.center_q)
                                           + CORNER[side][0] * k + WALK[side][0] * i);
                    next_cell.cell_r = t_coord'(int'(req.center_r)
                                           + CORNER[side][1] * k + WALK[side][1] * i);
                    next_cell.cell_s = t_coord'(int'(req.center_s)
                                           + CORNER[side][2] * k + WALK[side][2] * i);
                    next_cell.last   = (k == rad) && (i == k - 1) && (side == 5);
                    owe_cell(next_cell);
                end
            end
        end
    endfunction

    // Present one request and return in the time step where it is accepted.
    // With hold set, the channel goes quiet until every owed cell has come.
    task automatic send_request(input t_req req, input bit hold);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (hold && gap == 0)
            gap = 1;
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            while (hold && cells_due.size() != 0)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req_bus   <= req;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic check_cell(input t_cell got);
        t_cell want;
        if (cells_due.size() == 0) begin
            $error("unexpected cell q=%0d r=%0d s=%0d last=%0b",
                   got.cell_q, got.cell_r, got.cell_s, got.last);
            errors++;
            return;
        end
        want = cells_due.pop_front();
        if (got.cell_q !== want.cell_q) begin
            $error("cell_q: expected %0d, got %0d", want.cell_q, got.cell_q);
            errors++;
        end
        if (got.cell_r !== want.cell_r) begin
            $error("cell_r: expected %0d, got %0d", want.cell_r, got.cell_r);
            errors++;
        end
        if (got.cell_s !== want.cell_s) begin
            $error("cell_s: expected %0d, got %0d", want.cell_s, got.cell_s);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
        end
    endtask

    // Cell side: check on every handshake, and stall ready in random bursts.
    // All reads happen before this edge's updates land, so order is irrelevant.
    initial begin : cell_sink
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (cell_ready && cell_valid === 1'b1)
                check_cell(cell_bus);
            if (stall != 0) begin
                stall--;
                cell_ready <= 1'b0;
            end else begin
                cell_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // Watchdog: a long stretch with no handshake on either channel is a hang
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (cell_ready && cell_valid))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : stimulus
        t_req req;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed rows load their cells straight into the queue
        for (int idx = 0; idx < N_DIRECTED; idx++) begin
            req.op       = DIRECTED[idx].op;
            req.center_q = DIRECTED[idx].q;
            req.center_r = DIRECTED[idx].r;
            req.center_s = DIRECTED[idx].s;
            req.radius   = DIRECTED[idx].rad;
            send_request(req, 1'b0);
            case (DIRECTED[idx].chk)
                CHK_UNIT_RING: begin
                    foreach (UNIT_RING[c])
                        owe_cell(UNIT_RING[c]);
                end
                CHK_NONE: ;
                default: expand_request(req);
            endcase
        end

        // Random part: drain first, then a calm stretch and a mid-run drain
        for (int idx = 0; idx < N_RANDOM; idx++) begin
            calm         = (idx >= 40 && idx < 70);
            req.op       = 1'($urandom_range(0, 1));
            req.center_q = random_coord();
            req.center_r = random_coord();
            req.center_s = random_coord();
            req.radius   = random_radius();
            send_request(req, idx == 0 || idx == N_RANDOM / 2);
            expand_request(req);
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        // Wait for every owed cell, then watch a while for stray output
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
